// ----- src/vdib_pkg.sv -----
// Shared types and constants for the vertex dedup index builder.
// No dependencies; used by every module in src/ but vdib_table, including the checker.
package vdib_pkg;

	localparam int COMP_W = 32;
	localparam int CPV_W = 5;
	localparam int TOL_W = 31;
	localparam int IDX_W = 10;
	localparam int OUT_TDATA_W = 16;

	localparam int DEF_MAX_COMPONENTS = 16;
	localparam int DEF_TABLE_DEPTH = 1024;

	// 0.00001 in Q12.20, truncated
	localparam logic [TOL_W-1:0] TOL_RESET = 31'd10;
	localparam logic [CPV_W-1:0] CPV_RESET = 5'd8;

	typedef enum logic [0:0] {
		REG_CPV = 1'b0,
		REG_TOL = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OUT_MATCH = 2'd0,
		OUT_ADDED = 2'd1,
		OUT_FULL  = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

// ----- src/vdib_table.sv -----
// Unique-vertex table: one row holds a whole vertex, one write and one read port.
// Read data is registered, valid in the cycle after rd_en. Depends on nothing.
module vdib_table #(
	parameter int DEPTH = 1024,
	parameter int ROW_W = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [ROW_W-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [ROW_W-1:0]         rd_data
);

	logic [ROW_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- src/vdib_match.sv -----
// Per-component tolerance compare of the pending vertex against one table row.
// Depends on vdib_pkg.
module vdib_match #(
	parameter int MAX_COMPONENTS = vdib_pkg::DEF_MAX_COMPONENTS
) (
	input  logic [MAX_COMPONENTS-1:0][vdib_pkg::COMP_W-1:0] pend,
	input  logic [MAX_COMPONENTS-1:0][vdib_pkg::COMP_W-1:0] row,
	input  logic [vdib_pkg::TOL_W-1:0]                      tol,
	input  logic [vdib_pkg::CPV_W-1:0]                      stride,
	output logic                                            match
);

	localparam int DW = vdib_pkg::COMP_W + 1;

	logic [MAX_COMPONENTS-1:0] lane_ok;

	always_comb begin
		logic signed [DW-1:0] diff;
		logic signed [DW-1:0] tpos;
		logic signed [DW-1:0] tneg;
		tpos = signed'({{(DW-vdib_pkg::TOL_W){1'b0}}, tol});
		tneg = -tpos;
		for (int j = 0; j < MAX_COMPONENTS; j++) begin
			// exact difference, one bit wider than the operands
			diff = signed'({pend[j][vdib_pkg::COMP_W-1], pend[j]})
				- signed'({row[j][vdib_pkg::COMP_W-1], row[j]});
			lane_ok[j] = (vdib_pkg::CPV_W'(j) >= stride) || ((diff <= tpos) && (diff >= tneg));
		end
	end

	assign match = &lane_ok;

endmodule

// ----- src/vdib_ctrl.sv -----
// Sequencer: config registers, pending vertex, table scan, append and result register.
// Depends on vdib_pkg; drives vdib_table and consumes the vdib_match result.
module vdib_ctrl #(
	parameter int MAX_COMPONENTS = vdib_pkg::DEF_MAX_COMPONENTS,
	parameter int TABLE_DEPTH = vdib_pkg::DEF_TABLE_DEPTH
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            cfg_valid,
	output logic                                            cfg_ready,
	input  logic [0:0]                                      cfg_index,
	input  logic [vdib_pkg::TOL_W-1:0]                      cfg_data,
	input  logic                                            s_tvalid,
	output logic                                            s_tready,
	input  logic [vdib_pkg::COMP_W-1:0]                     comp_in,
	input  logic                                            new_mesh,
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	output logic [vdib_pkg::IDX_W-1:0]                      vertex_index,
	output vdib_pkg::outcome_t                              outcome,
	output logic [MAX_COMPONENTS-1:0][vdib_pkg::COMP_W-1:0] pend,
	output logic [vdib_pkg::TOL_W-1:0]                      tol,
	output logic [vdib_pkg::CPV_W-1:0]                      stride,
	input  logic                                            match,
	output logic                                            tbl_wr_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]                  tbl_wr_addr,
	output logic [MAX_COMPONENTS-1:0][vdib_pkg::COMP_W-1:0] tbl_wr_data,
	output logic                                            tbl_rd_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]                  tbl_rd_addr
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int PW = vdib_pkg::CPV_W;

	vdib_pkg::state_t state_q, state_d;

	logic [PW-1:0]                  cpv_q;
	logic [vdib_pkg::TOL_W-1:0]     tol_q;
	logic [MAX_COMPONENTS-1:0][vdib_pkg::COMP_W-1:0] pend_q;
	logic [PW-1:0]                  pcnt_q;
	logic [CW-1:0]                  ucnt_q;
	logic [CW-1:0]                  iss_q;
	logic [CW-1:0]                  chk_q;
	logic                           rd_vld_s1;
	logic [vdib_pkg::IDX_W-1:0]     res_idx_q;
	vdib_pkg::outcome_t             res_out_q;
	logic                           m_valid_q;
	logic [vdib_pkg::IDX_W-1:0]     m_idx_q;
	vdib_pkg::outcome_t             m_out_q;

	logic          accept;
	logic [PW-1:0] base_cnt;
	logic [PW-1:0] next_cnt;
	logic          vtx_done;
	logic          issue;
	logic          hit;
	logic          miss_all;
	logic          decide;
	logic          full;
	logic          append;
	logic          out_free;
	logic          load_out;

	// effective stride: 0 acts as 1, clamp at the lane count
	always_comb begin
		if (cpv_q == '0) begin
			stride = PW'(1);
		end else if (cpv_q > PW'(MAX_COMPONENTS)) begin
			stride = PW'(MAX_COMPONENTS);
		end else begin
			stride = cpv_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign accept = s_tvalid && s_tready;
	assign base_cnt = new_mesh ? '0 : pcnt_q;
	assign next_cnt = base_cnt + PW'(1);
	assign vtx_done = next_cnt >= stride;

	assign hit = (state_q == vdib_pkg::ST_SCAN) && rd_vld_s1 && match;
	assign miss_all = (state_q == vdib_pkg::ST_SCAN) && !rd_vld_s1 && (chk_q == ucnt_q);
	assign decide = hit || miss_all;
	assign full = ucnt_q >= CW'(TABLE_DEPTH);
	assign append = miss_all && !full;
	assign out_free = !m_valid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vdib_pkg::ST_IDLE: begin
				if (accept && vtx_done) begin
					state_d = vdib_pkg::ST_SCAN;
				end
			end
			vdib_pkg::ST_SCAN: begin
				if (decide) begin
					state_d = vdib_pkg::ST_EMIT;
				end
			end
			vdib_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = vdib_pkg::ST_IDLE;
				end
			end
			default: state_d = vdib_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		issue = 1'b0;
		load_out = 1'b0;
		case (state_q)
			vdib_pkg::ST_IDLE: s_tready = 1'b1;
			vdib_pkg::ST_SCAN: issue = (iss_q < ucnt_q) && !decide;
			vdib_pkg::ST_EMIT: load_out = out_free;
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdib_pkg::ST_IDLE;
			cpv_q <= vdib_pkg::CPV_RESET;
			tol_q <= vdib_pkg::TOL_RESET;
			pcnt_q <= '0;
			ucnt_q <= '0;
			iss_q <= '0;
			chk_q <= '0;
			rd_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_vld_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == vdib_pkg::REG_CPV) begin
					cpv_q <= cfg_data[PW-1:0];
				end else begin
					tol_q <= cfg_data;
				end
			end
			if (accept) begin
				pcnt_q <= vtx_done ? '0 : next_cnt;
				iss_q <= '0;
				chk_q <= '0;
			end else if (state_q == vdib_pkg::ST_SCAN) begin
				if (issue) begin
					iss_q <= iss_q + CW'(1);
				end
				if (rd_vld_s1 && !match) begin
					chk_q <= chk_q + CW'(1);
				end
			end
			if (accept && new_mesh) begin
				ucnt_q <= '0;
			end else if (append) begin
				ucnt_q <= ucnt_q + CW'(1);
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int j = 0; j < MAX_COMPONENTS; j++) begin
				if (base_cnt == PW'(j)) begin
					pend_q[j] <= comp_in;
				end
			end
		end
		if (decide) begin
			if (hit) begin
				res_idx_q <= vdib_pkg::IDX_W'(chk_q);
				res_out_q <= vdib_pkg::OUT_MATCH;
			end else if (full) begin
				res_idx_q <= '0;
				res_out_q <= vdib_pkg::OUT_FULL;
			end else begin
				res_idx_q <= vdib_pkg::IDX_W'(ucnt_q);
				res_out_q <= vdib_pkg::OUT_ADDED;
			end
		end
		if (load_out) begin
			m_idx_q <= res_idx_q;
			m_out_q <= res_out_q;
		end
	end

	// appended row keeps only the active components, the rest read back as zero
	always_comb begin
		for (int j = 0; j < MAX_COMPONENTS; j++) begin
			tbl_wr_data[j] = (PW'(j) < stride) ? pend_q[j] : '0;
		end
	end

	// a row is written at ucnt_q; reads in flight only touch rows below it
	assign tbl_wr_en = append;
	assign tbl_wr_addr = ucnt_q[AW-1:0];
	assign tbl_rd_en = issue;
	assign tbl_rd_addr = iss_q[AW-1:0];

	assign pend = pend_q;
	assign tol = tol_q;
	assign m_tvalid = m_valid_q;
	assign vertex_index = m_idx_q;
	assign outcome = m_out_q;

endmodule

// ----- src/vertex_dedup_index_builder.sv -----
// Vertex dedup index builder: collects components into a vertex, then scans the
// unique table one whole vertex per cycle. A component that does not close a vertex leaves
// s_tready high for the next one; after a closing one, s_tready returns with m_tvalid,
// unless an older result still stalls. Reset is asynchronous and active low: table empty,
// no partial vertex, config defaults. Depends on vdib_pkg, ctrl, match, table.
module vertex_dedup_index_builder #(
	parameter int MAX_COMPONENTS = vdib_pkg::DEF_MAX_COMPONENTS,
	parameter int TABLE_DEPTH = vdib_pkg::DEF_TABLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [0:0]                          cfg_index,
	input  logic [vdib_pkg::TOL_W-1:0]          cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [vdib_pkg::COMP_W-1:0]         s_tdata,   // [31:0] component_value
	input  logic [0:0]                          s_tuser,   // [0] new_mesh
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [vdib_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [9:0] vertex_index, rest zero
	output logic [1:0]                          m_tuser    // [1:0] outcome
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int ROW_W = MAX_COMPONENTS * vdib_pkg::COMP_W;

	logic [MAX_COMPONENTS-1:0][vdib_pkg::COMP_W-1:0] pend;
	logic [MAX_COMPONENTS-1:0][vdib_pkg::COMP_W-1:0] wr_row;
	logic [ROW_W-1:0]                                 rd_row;
	logic [vdib_pkg::TOL_W-1:0]                       tol;
	logic [vdib_pkg::CPV_W-1:0]                       stride;
	logic                                             match;
	logic                                             wr_en;
	logic [AW-1:0]                                    wr_addr;
	logic                                             rd_en;
	logic [AW-1:0]                                    rd_addr;
	logic [vdib_pkg::IDX_W-1:0]                       vertex_index;
	vdib_pkg::outcome_t                               outcome;

	vdib_ctrl #(
		.MAX_COMPONENTS(MAX_COMPONENTS),
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.comp_in(s_tdata),
		.new_mesh(s_tuser[0]),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.vertex_index(vertex_index),
		.outcome(outcome),
		.pend(pend),
		.tol(tol),
		.stride(stride),
		.match(match),
		.tbl_wr_en(wr_en),
		.tbl_wr_addr(wr_addr),
		.tbl_wr_data(wr_row),
		.tbl_rd_en(rd_en),
		.tbl_rd_addr(rd_addr)
	);

	vdib_table #(
		.DEPTH(TABLE_DEPTH),
		.ROW_W(ROW_W)
	) u_table (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_row),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_row)
	);

	vdib_match #(
		.MAX_COMPONENTS(MAX_COMPONENTS)
	) u_match (
		.pend(pend),
		.row(rd_row),
		.tol(tol),
		.stride(stride),
		.match(match)
	);

	assign m_tdata = {{(vdib_pkg::OUT_TDATA_W - vdib_pkg::IDX_W){1'b0}}, vertex_index};
	assign m_tuser = outcome;

endmodule

// ----- src/vdib_chk.sv -----
// Port-level checker for vertex_dedup_index_builder, bound to the top level.
// Depends on vdib_pkg.
module vdib_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [vdib_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]                       m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// dropped vertex reports index zero
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == vdib_pkg::OUT_FULL) |-> (m_tdata == '0))
		else $error("overflow result with nonzero index");

	// a fresh result only follows a cycle in which no component could be taken
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while input side was open");

	// input side stays closed while a new result is being loaded
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result directly after a component transfer");

endmodule

bind vertex_dedup_index_builder vdib_chk u_vdib_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for vertex_dedup_index_builder: streams vertex components, predicts
// each returned index and outcome with a behavioral weld model, and compares in order.
// Depends on vdib_pkg and the RTL under src/.
module tb;

	localparam int MAXC = vdib_pkg::DEF_MAX_COMPONENTS;
	localparam int DEPTH = vdib_pkg::DEF_TABLE_DEPTH;
	localparam int HOLDOFF = 8;
	localparam int WATCHDOG_LIMIT = 600;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 44;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct {
		logic [vdib_pkg::IDX_W-1:0] idx;
		vdib_pkg::outcome_t oc;
	} index_result_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [vdib_pkg::TOL_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [vdib_pkg::COMP_W-1:0] s_tdata;   // [31:0] component_value
	logic [0:0] s_tuser;                    // [0] new_mesh
	logic m_tvalid;
	logic m_tready;
	logic [vdib_pkg::OUT_TDATA_W-1:0] m_tdata;   // [9:0] vertex_index, rest zero
	logic [1:0] m_tuser;                        // [1:0] outcome

	// weld model state
	logic [vdib_pkg::COMP_W-1:0] weld_table [DEPTH][MAXC];
	logic [vdib_pkg::COMP_W-1:0] weld_pending [MAXC];
	int weld_pend_cnt;
	int weld_fill;
	logic [vdib_pkg::CPV_W-1:0] cpv_shadow;
	logic [vdib_pkg::TOL_W-1:0] tol_shadow;

	index_result_t awaited_indices[$];
	int mismatches;
	int quiet_cycles;
	bit idle_on;

	vertex_dedup_index_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic log_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int active_stride();
		if (cpv_shadow == 0)
			return 1;
		if (cpv_shadow > MAXC)
			return MAXC;
		return int'(cpv_shadow);
	endfunction

	function automatic bit entry_close(input int e, input int stride);
		longint d;
		for (int j = 0; j < stride; j++) begin
			d = longint'($signed(weld_pending[j])) - longint'($signed(weld_table[e][j]));
			if (d < 0)
				d = -d;
			if (d > longint'(tol_shadow))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Advance the weld model by one component; queue the result if a vertex closes.
	task automatic weld_component(input logic [vdib_pkg::COMP_W-1:0] value, input logic nm);
		int stride;
		bit hit;
		index_result_t r;
		stride = active_stride();
		if (nm) begin
			weld_fill = 0;
			weld_pend_cnt = 0;
		end
		weld_pending[weld_pend_cnt] = value;
		weld_pend_cnt++;
		if (weld_pend_cnt < stride)
			return;
		weld_pend_cnt = 0;
		hit = 1'b0;
		for (int e = 0; e < weld_fill && !hit; e++) begin
			if (entry_close(e, stride)) begin
				hit = 1'b1;
				r.idx = vdib_pkg::IDX_W'(e);
				r.oc = vdib_pkg::OUT_MATCH;
			end
		end
		if (!hit) begin
			if (weld_fill >= DEPTH) begin
				r.idx = '0;
				r.oc = vdib_pkg::OUT_FULL;
			end else begin
				for (int j = 0; j < MAXC; j++)
					weld_table[weld_fill][j] = (j < stride) ? weld_pending[j] : '0;
				r.idx = vdib_pkg::IDX_W'(weld_fill);
				r.oc = vdib_pkg::OUT_ADDED;
				weld_fill++;
			end
		end
		awaited_indices = {awaited_indices, r};
	endtask

	task automatic send_component(input logic [vdib_pkg::COMP_W-1:0] value, input logic nm);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= nm;
		do @(posedge clk); while (!s_tready);
		weld_component(value, nm);
	endtask

	// Stop sending, let every expected result arrive, then give the block time to go idle.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (awaited_indices.size() != 0);
		repeat (HOLDOFF) @(posedge clk);
	endtask

	task automatic write_reg(input vdib_pkg::reg_idx_t idx,
		input logic [vdib_pkg::TOL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == vdib_pkg::REG_CPV)
			cpv_shadow = val[vdib_pkg::CPV_W-1:0];
		else
			tol_shadow = val;
		@(posedge clk);
	endtask

	// Receiver: random stall bursts while idle_on is set.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 6) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		index_result_t r;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_indices.size() == 0) begin
				log_mismatch($sformatf("unexpected result idx=%0d outcome=%0d",
					m_tdata, m_tuser));
			end else begin
				r = awaited_indices.pop_front();
				if (m_tdata !== {{(vdib_pkg::OUT_TDATA_W-vdib_pkg::IDX_W){1'b0}}, r.idx})
					log_mismatch($sformatf("vertex_index got %0d want %0d", m_tdata, r.idx));
				if (m_tuser !== r.oc)
					log_mismatch($sformatf("outcome got %0d want %0d", m_tuser, r.oc));
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		send_component(32'h8000_0000, 1'b0);
		send_component(32'h7FFF_FFFF, 1'b0);
		send_component(32'h0000_0000, 1'b0);
		send_component(32'hFFFF_FFFF, 1'b0);
		send_component(32'h0000_0001, 1'b0);
		send_component(32'h0010_0000, 1'b0);
		send_component(32'hFFF0_0000, 1'b0);
		send_component(32'h5555_AAAA, 1'b0);
		quiesce();
	endtask

	// Count dropped while a vertex is partly collected: next component closes it.
	task automatic test_count_lowered_midvertex();
		send_component(32'h8000_000A, 1'b0);
		send_component(32'h7FFF_FFFF, 1'b0);
		send_component(32'h0000_0123, 1'b0);
		quiesce();
		write_reg(vdib_pkg::REG_CPV, 31'd2);
		send_component(32'hDEAD_BEEF, 1'b0);
		quiesce();
	endtask

	// Full-scale differences must not wrap.
	task automatic test_difference_extremes();
		write_reg(vdib_pkg::REG_TOL, 31'h7FFF_FFFF);
		send_component(32'h7FFF_FFFF, 1'b0);
		send_component(32'h8000_0000, 1'b0);
		quiesce();
		write_reg(vdib_pkg::REG_CPV, 31'd0);
		send_component(32'h0000_0000, 1'b0);
		quiesce();
	endtask

	// Entries stored with a smaller count read as zero in the upper slots.
	task automatic test_zero_filled_slots();
		write_reg(vdib_pkg::REG_TOL, 31'd10);
		write_reg(vdib_pkg::REG_CPV, 31'd4);
		send_component(32'h7FFF_FFF5, 1'b0);
		send_component(32'h8000_000A, 1'b0);
		send_component(32'h0000_0000, 1'b0);
		send_component(32'h0000_000B, 1'b0);
		send_component(32'h7FFF_FFF5, 1'b0);
		send_component(32'h8000_000A, 1'b0);
		send_component(32'hFFFF_FFF6, 1'b0);
		send_component(32'h0000_000A, 1'b0);
		quiesce();
	endtask

	task automatic test_new_mesh_clears();
		write_reg(vdib_pkg::REG_CPV, 31'd2);
		send_component(32'h0000_0005, 1'b0);
		send_component(32'h0000_0006, 1'b1);
		send_component(32'h0000_0007, 1'b0);
		quiesce();
	endtask

	function automatic logic [vdib_pkg::COMP_W-1:0] nudge(
		input logic [vdib_pkg::COMP_W-1:0] base);
		longint off;
		longint v;
		case ($urandom_range(0, 3))
			0: off = 0;
			1: off = longint'(tol_shadow);
			2: off = longint'(tol_shadow) + 1;
			default: off = longint'($urandom_range(0, tol_shadow));
		endcase
		if ($urandom_range(0, 1))
			off = -off;
		v = longint'($signed(base)) + off;
		if (v > S32_MAX)
			v = S32_MAX;
		if (v < S32_MIN)
			v = S32_MIN;
		return v[vdib_pkg::COMP_W-1:0];
	endfunction

	function automatic logic [vdib_pkg::COMP_W-1:0] extreme_value();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return 32'h0000_0001;
		endcase
	endfunction

	task automatic pick_config(input int phase);
		logic [vdib_pkg::CPV_W-1:0] cpv;
		logic [vdib_pkg::TOL_W-1:0] tol;
		logic [vdib_pkg::TOL_W-1:0] junk;
		case (phase)
			0: begin cpv = 5'd1; tol = 31'd0; end
			1: begin cpv = 5'd16; tol = 31'h7FFF_FFFF; end
			2: begin cpv = 5'd31; tol = vdib_pkg::TOL_W'($urandom); end
			default: begin
				case ($urandom_range(0, 9))
					0: cpv = 5'd0;
					1: cpv = 5'd16;
					2: cpv = vdib_pkg::CPV_W'($urandom_range(17, 31));
					3: cpv = 5'd1;
					default: cpv = vdib_pkg::CPV_W'($urandom_range(2, 4));
				endcase
				case ($urandom_range(0, 5))
					0: tol = 31'd0;
					1: tol = 31'h7FFF_FFFF;
					2: tol = vdib_pkg::TOL_W'($urandom);
					default: tol = vdib_pkg::TOL_W'($urandom_range(0, 64));
				endcase
			end
		endcase
		// upper data bits are don't-care for the count register
		junk = vdib_pkg::TOL_W'($urandom);
		if ($urandom_range(0, 1)) begin
			write_reg(vdib_pkg::REG_TOL, tol);
			write_reg(vdib_pkg::REG_CPV, {junk[vdib_pkg::TOL_W-1:vdib_pkg::CPV_W], cpv});
		end else begin
			write_reg(vdib_pkg::REG_CPV, {junk[vdib_pkg::TOL_W-1:vdib_pkg::CPV_W], cpv});
			write_reg(vdib_pkg::REG_TOL, tol);
		end
	endtask

	// Mostly whole vertices built near stored entries, with random mesh restarts,
	// mid-vertex clears and raw noise mixed in.
	task automatic test_random_welding();
		int mode;
		int target;
		int slot;
		bit restart;
		logic nm;
		logic [vdib_pkg::COMP_W-1:0] v;
		mode = 0;
		target = 0;
		restart = 1'b0;
		for (int phase = 0; phase < PHASES; phase++) begin
			idle_on = (phase != PHASES - 1);
			pick_config(phase);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (weld_pend_cnt == 0) begin
					mode = $urandom_range(0, 9);
					restart = ($urandom_range(0, 15) == 0) || (weld_fill > 40);
					target = (weld_fill != 0) ? $urandom_range(0, weld_fill - 1) : 0;
				end
				slot = weld_pend_cnt;
				case (mode)
					0, 1: v = $urandom;
					7: v = extreme_value();
					8: v = vdib_pkg::COMP_W'($urandom_range(0, 3));
					9: v = weld_table[target][slot];
					default: v = (weld_fill != 0) ? nudge(weld_table[target][slot]) : $urandom;
				endcase
				nm = (restart && slot == 0) || ($urandom_range(0, 63) == 0);
				restart = 1'b0;
				send_component(v, nm);
				if (phase == 4 && n == PHASE_ITEMS / 2) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (awaited_indices.size() != 0);
				end
			end
			quiesce();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= vdib_pkg::REG_CPV;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		mismatches = 0;
		idle_on = 1'b1;
		cpv_shadow = vdib_pkg::CPV_RESET;
		tol_shadow = vdib_pkg::TOL_RESET;
		weld_pend_cnt = 0;
		weld_fill = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_count_lowered_midvertex();
		test_difference_extremes();
		test_zero_filled_slots();
		test_new_mesh_clears();
		test_random_welding();

		quiesce();
		repeat (20) @(posedge clk);
		if (awaited_indices.size() != 0)
			log_mismatch($sformatf("%0d results never arrived", awaited_indices.size()));
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/vdib_pkg.sv
src/vdib_table.sv
src/vdib_match.sv
src/vdib_ctrl.sv
src/vertex_dedup_index_builder.sv
src/vdib_chk.sv
test/tb.sv
